@@ rtl/eaws_pkg.sv @@
// Package for the EEPROM aligned write sequencer.
// Holds bus codes, key words, reset values and the result and bundle types.
// No dependencies.
package eaws_pkg;

  localparam int OFFSET_BITS_DEF = 16;

  localparam logic [31:0] BASE_RESET = 32'h0808_0000;
  localparam logic [31:0] KEY_FIRST  = 32'h89AB_CDEF;
  localparam logic [31:0] KEY_SECOND = 32'h0203_0405;
  localparam logic [31:0] LOCK_BIT   = 32'h0000_0001;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_LOCK = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef struct packed {
    logic        accepted;
    logic        write_active;
    logic [1:0]  bus_kind;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic [1:0]  bus_size;
  } result_t;

  // All results caused by one input item; cnt is 1..3
  typedef struct packed {
    logic [1:0]       cnt;
    result_t [2:0]    res;
  } bundle_t;

endpackage

@@ rtl/eaws_in_if.sv @@
// Input channel of the EEPROM aligned write sequencer.
// Valid/ready handshake with the start/poll item fields. No dependencies.
interface eaws_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] start_offset;
  logic [15:0] start_size;
  logic        zero_fill;
  logic        flash_busy;
  logic        pe_locked;
  logic [31:0] data_word;

  modport source (output valid, mode, start_offset, start_size, zero_fill,
                  flash_busy, pe_locked, data_word, input ready);
  modport sink (input valid, mode, start_offset, start_size, zero_fill,
                flash_busy, pe_locked, data_word, output ready);
endinterface

@@ rtl/eaws_out_if.sv @@
// Result channel of the EEPROM aligned write sequencer.
// Valid/ready handshake with the bus write result fields. No dependencies.
interface eaws_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        write_active;
  logic [1:0]  bus_kind;
  logic [31:0] bus_address;
  logic [31:0] bus_data;
  logic [1:0]  bus_size;
  logic        last;

  modport source (output valid, accepted, write_active, bus_kind, bus_address,
                  bus_data, bus_size, last, input ready);
  modport sink (input valid, accepted, write_active, bus_kind, bus_address,
                bus_data, bus_size, last, output ready);
endinterface

@@ rtl/eeprom_aligned_write_sequencer_top.sv @@
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      mode, offset, size, zero_fill, status bits, data_word
// out_ch    out  valid/ready      accepted, write_active, bus_kind/address/data/size, last
// cfg       in   cfg_we           cfg_wdata -> eeprom_base
//
// An item is decoded in the cycle it is accepted; its one to three results are
// registered as a bundle and leave one per cycle while out_ch is ready. Two
// bundle slots: a new item is taken while the previous bundle still drains or
// is stalled. Reset (rst_n, synchronous) clears the run state and both slots
// and restores eeprom_base; no clearing pass.
// Depends on eaws_pkg, eaws_in_if, eaws_out_if.
module eeprom_aligned_write_sequencer_top #(
  parameter int OFFSET_BITS = eaws_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  eaws_in_if.sink     in_ch,
  eaws_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]            base_r;
  logic                   active_r;
  logic [15:0]            left_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic                   fz_r;

  eaws_pkg::bundle_t slot0_r, slot1_r, bnd;
  logic              v0_r, v1_r;
  logic [1:0]        idx_r;

  logic                   start, push, out_last, pop;
  logic [OFFSET_BITS-1:0] off_start, w_off, new_off;
  logic [15:0]            w_left, new_left;
  logic                   w_fz, do_write;
  logic [2:0]             step;
  logic [1:0]             wsize;
  logic [31:0]            wdata;
  eaws_pkg::result_t      wr_res, none_res;
  logic [1:0]             n;

  assign start     = !in_ch.mode;
  assign off_start = OFFSET_BITS'(in_ch.start_offset);
  assign w_off     = start ? off_start : off_r;
  assign w_left    = start ? in_ch.start_size : left_r;
  assign w_fz      = start ? in_ch.zero_fill : fz_r;
  assign do_write  = (w_left != 16'd0) && !in_ch.flash_busy && (start != active_r);

  always_comb begin
    if (w_left >= 16'd4 && w_off[1:0] == 2'b00) begin
      step  = 3'd4;
      wsize = eaws_pkg::SIZE_WORD;
      wdata = in_ch.data_word;
    end else if (w_left >= 16'd2 && !w_off[0]) begin
      step  = 3'd2;
      wsize = eaws_pkg::SIZE_HALF;
      wdata = {16'h0000, in_ch.data_word[15:0]};
    end else begin
      step  = 3'd1;
      wsize = eaws_pkg::SIZE_BYTE;
      wdata = {24'h000000, in_ch.data_word[7:0]};
    end
  end

  assign new_left = w_left - 16'(step);
  assign new_off  = w_off + OFFSET_BITS'(step);

  always_comb begin
    wr_res              = '0;
    wr_res.accepted     = start;
    wr_res.write_active = 1'b1;
    wr_res.bus_kind     = eaws_pkg::KIND_DATA;
    wr_res.bus_address  = base_r + 32'(w_off);
    wr_res.bus_data     = w_fz ? 32'd0 : wdata;
    wr_res.bus_size     = wsize;
    none_res            = '0;
  end

  always_comb begin
    bnd = '0;
    n   = 2'd0;
    if (start) begin
      if (active_r) begin
        bnd.res[0].write_active = 1'b1;
        n = 2'd1;
      end else begin
        if (in_ch.pe_locked) begin
          bnd.res[0] = '{1'b1, 1'b1, eaws_pkg::KIND_KEY, 32'd0, eaws_pkg::KEY_FIRST,
                         eaws_pkg::SIZE_WORD};
          bnd.res[1] = '{1'b1, 1'b1, eaws_pkg::KIND_KEY, 32'd0, eaws_pkg::KEY_SECOND,
                         eaws_pkg::SIZE_WORD};
          n = 2'd2;
        end
        if (do_write) begin
          bnd.res[n] = wr_res;
          n = n + 2'd1;
        end
        if (n == 2'd0) begin
          bnd.res[0]              = none_res;
          bnd.res[0].accepted     = 1'b1;
          bnd.res[0].write_active = 1'b1;
          n = 2'd1;
        end
      end
    end else begin
      n = 2'd1;
      if (!active_r || in_ch.flash_busy) begin
        bnd.res[0]              = none_res;
        bnd.res[0].write_active = active_r;
      end else if (left_r == 16'd0) begin
        bnd.res[0] = '{1'b0, 1'b0, eaws_pkg::KIND_LOCK, 32'd0, eaws_pkg::LOCK_BIT,
                       eaws_pkg::SIZE_WORD};
      end else begin
        bnd.res[0] = wr_res;
      end
    end
    bnd.cnt = n;
  end

  assign in_ch.ready = !v1_r;
  assign push        = in_ch.valid && !v1_r;
  assign out_last    = (idx_r == slot0_r.cnt - 2'd1);
  assign pop         = v0_r && out_ch.ready && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= eaws_pkg::BASE_RESET;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      left_r   <= '0;
      off_r    <= '0;
      fz_r     <= 1'b0;
    end else if (push) begin
      if (start && !active_r) begin
        active_r <= 1'b1;
        fz_r     <= in_ch.zero_fill;
        off_r    <= do_write ? new_off : off_start;
        left_r   <= do_write ? new_left : in_ch.start_size;
      end else if (!start && active_r && !in_ch.flash_busy) begin
        if (left_r == 16'd0) begin
          active_r <= 1'b0;
        end else begin
          off_r  <= new_off;
          left_r <= new_left;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      if (v0_r && out_ch.ready) begin
        idx_r <= out_last ? 2'd0 : idx_r + 2'd1;
      end
      if (pop) begin
        if (v1_r) begin
          slot0_r <= slot1_r;
          v1_r    <= 1'b0;
        end else begin
          v0_r <= push;
          if (push) begin
            slot0_r <= bnd;
          end
        end
      end else if (push) begin
        if (!v0_r) begin
          slot0_r <= bnd;
          v0_r    <= 1'b1;
        end else begin
          slot1_r <= bnd;
          v1_r    <= 1'b1;
        end
      end
    end
  end

  assign out_ch.valid        = v0_r;
  assign out_ch.accepted     = slot0_r.res[idx_r].accepted;
  assign out_ch.write_active = slot0_r.res[idx_r].write_active;
  assign out_ch.bus_kind     = slot0_r.res[idx_r].bus_kind;
  assign out_ch.bus_address  = slot0_r.res[idx_r].bus_address;
  assign out_ch.bus_data     = slot0_r.res[idx_r].bus_data;
  assign out_ch.bus_size     = slot0_r.res[idx_r].bus_size;
  assign out_ch.last         = out_last;

endmodule

@@ rtl/eaws_checker.sv @@
// Port-level checks for the EEPROM aligned write sequencer.
// Bound to eeprom_aligned_write_sequencer_top; depends on eaws_pkg.
module eaws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_write_active,
  input logic [1:0]  out_bus_kind,
  input logic [31:0] out_bus_address,
  input logic [31:0] out_bus_data,
  input logic [1:0]  out_bus_size,
  input logic        out_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bus_data)
      && $stable(out_bus_kind) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_kind == eaws_pkg::KIND_NONE |->
      out_bus_address == 32'd0 && out_bus_data == 32'd0
      && out_bus_size == eaws_pkg::SIZE_BYTE && out_last)
    else $error("idle result carries bus fields");

  a_lock_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_kind == eaws_pkg::KIND_LOCK |->
      out_last && !out_write_active && !out_accepted
      && out_bus_data == eaws_pkg::LOCK_BIT)
    else $error("bad lock write");

  a_key_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_bus_kind == eaws_pkg::KIND_KEY
      && out_bus_data == eaws_pkg::KEY_FIRST |=>
      out_valid && out_bus_kind == eaws_pkg::KIND_KEY
      && out_bus_data == eaws_pkg::KEY_SECOND)
    else $error("second key does not follow first");

endmodule

bind eeprom_aligned_write_sequencer_top eaws_checker u_eaws_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_accepted     (out_ch.accepted),
  .out_write_active (out_ch.write_active),
  .out_bus_kind     (out_ch.bus_kind),
  .out_bus_address  (out_ch.bus_address),
  .out_bus_data     (out_ch.bus_data),
  .out_bus_size     (out_ch.bus_size),
  .out_last         (out_ch.last)
);
